>>> rtl/core/vrs_pkg.sv
// Shared types, codes and defaults for the variable record stack.
`timescale 1ns / 1ps
`default_nettype none
package vrs_pkg;

	localparam int STORE_BYTES_DEF  = 1024;
	localparam int HEADER_BYTES_DEF = 4;
	localparam int MAX_READ_DEF     = 64;

	// bytes of the length word that carry value; header bytes above are zero
	localparam int LEN_BYTES = 4;

	localparam int FUNC_W    = 2;
	localparam int REC_LEN_W = 10;
	localparam int WANT_W    = 7;
	localparam int BYTE_W    = 8;
	localparam int STATUS_W  = 2;
	localparam int FREE_W    = 11;

	typedef enum logic [FUNC_W-1:0] {
		FN_CLEAR = 2'd0,
		FN_PUSH  = 2'd1,
		FN_POP   = 2'd2,
		FN_PEEK  = 2'd3
	} func_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK      = 2'd0,
		ST_NO_ROOM = 2'd1,
		ST_EMPTY   = 2'd2
	} status_t;

	typedef struct packed {
		logic capture;
		logic do_clear;
		logic push_step;
		logic read_start;
		logic hdr_write;
		logic hdr_rd_addr;
		logic hdr_acc;
		logic calc;
		logic byte_rd;
		logic emit_single;
		logic emit_byte;
	} cmd_t;

	typedef struct packed {
		func_t func;
		logic  push_commit;
		logic  stack_empty;
		logic  hdr_last;
		logic  idx_zero;
		logic  n_zero;
		logic  byte_last;
		logic  out_free;
	} sts_t;

endpackage
`default_nettype wire

>>> rtl/core/vrs_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module vrs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

>>> rtl/core/vrs_ctrl.sv
// Sequencing state machine for the variable record stack.
`timescale 1ns / 1ps
`default_nettype none
module vrs_ctrl (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         req_valid,
	output logic              req_stall,
	input  wire vrs_pkg::sts_t sts,
	output vrs_pkg::cmd_t     cmd
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_OP,
		S_HWR,
		S_HRA,
		S_HRD,
		S_CALC,
		S_BRA,
		S_BEM,
		S_EMIT
	} state_t;

	state_t state_q;
	state_t state_d;

	assign req_stall = (state_q != S_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_OP;
				end
			end
			S_OP: begin
				unique case (sts.func)
					vrs_pkg::FN_CLEAR: begin
						cmd.do_clear = 1'b1;
						state_d      = S_EMIT;
					end
					vrs_pkg::FN_PUSH: begin
						cmd.push_step = 1'b1;
						state_d       = sts.push_commit ? S_HWR : S_EMIT;
					end
					vrs_pkg::FN_POP, vrs_pkg::FN_PEEK: begin
						cmd.read_start = 1'b1;
						state_d        = sts.stack_empty ? S_EMIT : S_HRA;
					end
					default: state_d = S_EMIT;
				endcase
			end
			S_HWR: begin
				cmd.hdr_write = 1'b1;
				if (sts.hdr_last) begin
					state_d = S_EMIT;
				end
			end
			S_HRA: begin
				cmd.hdr_rd_addr = 1'b1;
				state_d         = S_HRD;
			end
			S_HRD: begin
				cmd.hdr_acc = 1'b1;
				state_d     = sts.idx_zero ? S_CALC : S_HRA;
			end
			S_CALC: begin
				cmd.calc = 1'b1;
				state_d  = sts.n_zero ? S_EMIT : S_BRA;
			end
			S_BRA: begin
				cmd.byte_rd = 1'b1;
				state_d     = S_BEM;
			end
			S_BEM: begin
				if (sts.out_free) begin
					cmd.emit_byte = 1'b1;
					state_d       = sts.byte_last ? S_IDLE : S_BRA;
				end
			end
			S_EMIT: begin
				if (sts.out_free) begin
					cmd.emit_single = 1'b1;
					state_d         = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
`default_nettype wire

>>> rtl/core/vrs_datapath.sv
// Stack pointers, push state, byte store and result register.
`timescale 1ns / 1ps
`default_nettype none
module vrs_datapath #(
	parameter int STORE_BYTES  = vrs_pkg::STORE_BYTES_DEF,
	parameter int HEADER_BYTES = vrs_pkg::HEADER_BYTES_DEF,
	parameter int MAX_READ     = vrs_pkg::MAX_READ_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire vrs_pkg::cmd_t                   cmd,
	output vrs_pkg::sts_t                        sts,
	input  wire logic [vrs_pkg::FUNC_W-1:0]      func,
	input  wire logic [vrs_pkg::REC_LEN_W-1:0]   record_length,
	input  wire logic [vrs_pkg::WANT_W-1:0]      wanted_bytes,
	input  wire logic [vrs_pkg::BYTE_W-1:0]      data_byte,
	input  wire logic                            end_of_record,
	output logic                                 rsp_valid,
	input  wire logic                            rsp_stall,
	output logic      [vrs_pkg::STATUS_W-1:0]    status,
	output logic      [vrs_pkg::BYTE_W-1:0]      out_byte,
	output logic                                 byte_valid,
	output logic                                 last,
	output logic      [vrs_pkg::FREE_W-1:0]      free_bytes,
	output logic                                 is_empty
);

	localparam int AW   = $clog2(STORE_BYTES);
	localparam int TW   = AW + 1;
	localparam int CW   = ((TW > vrs_pkg::FREE_W) ? TW : vrs_pkg::FREE_W) + 1;
	localparam int HIW  = (HEADER_BYTES > 1) ? $clog2(HEADER_BYTES) : 1;
	localparam int KW   = $clog2(MAX_READ + 1);
	localparam int RLW  = vrs_pkg::REC_LEN_W;
	localparam int BW   = vrs_pkg::BYTE_W;

	localparam logic [TW-1:0]  STORE_T  = TW'(STORE_BYTES);
	localparam logic [TW-1:0]  HB_T     = TW'(HEADER_BYTES);
	localparam logic [CW-1:0]  HB_C     = CW'(HEADER_BYTES);
	localparam logic [CW-1:0]  MAXR_C   = CW'(MAX_READ);
	localparam logic [HIW-1:0] HB_LAST  = HIW'(HEADER_BYTES - 1);

	// captured item
	vrs_pkg::func_t   func_q;
	logic [RLW-1:0]   rec_len_q;
	logic [vrs_pkg::WANT_W-1:0] want_q;
	logic [BW-1:0]    byte_q;
	logic             eor_q;

	// stack and push state
	logic [TW-1:0]    top_q;
	logic             push_active_q;
	logic [TW-1:0]    push_base_q;
	logic [RLW-1:0]   push_index_q;
	logic             push_rejected_q;

	// sequencing scratch
	vrs_pkg::status_t res_status_q;
	logic [HIW-1:0]   idx_q;
	logic [TW-1:0]    len_q;
	logic [TW-1:0]    rdbase_q;
	logic [KW-1:0]    n_q;
	logic [KW-1:0]    k_q;
	logic             oob_q;

	// result register
	logic                   out_valid_q;
	vrs_pkg::status_t       out_status_q;
	logic [BW-1:0]          out_byte_q;
	logic                   out_bv_q;
	logic                   out_last_q;
	logic [vrs_pkg::FREE_W-1:0] out_free_q;
	logic                   out_empty_q;

	// RAM
	logic            ram_we;
	logic [AW-1:0]   ram_waddr;
	logic [BW-1:0]   ram_wdata;
	logic            ram_re;
	logic [AW-1:0]   ram_raddr;
	logic [BW-1:0]   ram_rdata;
	logic [BW-1:0]   rd_byte;

	// push decode
	logic            first;
	logic [CW-1:0]   len_c;
	logic [CW-1:0]   top_c;
	logic            rej_now;
	logic            eff_rej;
	logic [TW-1:0]   eff_base;
	logic [CW-1:0]   plen;
	logic [RLW-1:0]  eff_idx;
	logic            do_wr;
	logic [RLW-1:0]  idx_next;
	logic            commit;
	logic            rej_clr;
	logic [TW-1:0]   push_addr;

	// header write
	logic [CW-1:0]   hdr_len;
	logic [CW-1:0]   hdr_sh;
	logic [BW-1:0]   hdr_byte;
	logic [TW-1:0]   hdr_base;
	logic [TW-1:0]   hdr_pos;

	// header read and length calculation
	logic [TW-1:0]   hra;
	logic [TW+BW-1:0] len_cat;
	logic [TW-1:0]   data_c;
	logic            data_fits;
	logic [TW-1:0]   room;
	logic [TW-1:0]   len_clamp;
	logic [CW-1:0]   m_want;
	logic [CW-1:0]   m_len;
	logic [CW-1:0]   m_1;
	logic [CW-1:0]   m_2;
	logic [KW-1:0]   n_c;
	logic [TW-1:0]   byte_addr;
	logic            out_free;

	assign first    = !push_active_q;
	assign len_c    = CW'(rec_len_q);
	assign top_c    = CW'(top_q);
	assign rej_now  = top_c < (len_c + HB_C);
	assign eff_rej  = first ? rej_now : push_rejected_q;
	assign eff_base = first ? (top_q - TW'(rec_len_q)) : push_base_q;
	assign plen     = first ? len_c : CW'(top_q - push_base_q);
	assign eff_idx  = first ? '0 : push_index_q;
	assign do_wr    = !eff_rej && (CW'(eff_idx) < plen);
	assign idx_next = eff_idx + RLW'(do_wr);
	assign commit   = !eff_rej && (eor_q || (CW'(idx_next) >= plen));
	assign rej_clr  = eor_q || (first && (rec_len_q == '0));
	assign push_addr = eff_base + TW'(eff_idx);

	assign hdr_len  = CW'(top_q - push_base_q);
	assign hdr_sh   = hdr_len >> {idx_q, 3'b000};
	assign hdr_byte = (32'(idx_q) < 32'(vrs_pkg::LEN_BYTES)) ? hdr_sh[BW-1:0] : '0;
	assign hdr_base = push_base_q - HB_T;
	assign hdr_pos  = hdr_base + TW'(idx_q);

	assign hra       = top_q + TW'(idx_q);
	assign rd_byte   = oob_q ? '0 : ram_rdata;
	assign len_cat   = {len_q, rd_byte};
	assign data_c    = top_q + HB_T;
	assign data_fits = data_c <= STORE_T;
	assign room      = data_fits ? (STORE_T - data_c) : '0;
	assign len_clamp = (len_q < room) ? len_q : room;
	assign m_want    = CW'(want_q);
	assign m_len     = CW'(len_clamp);
	assign m_1       = (m_want < m_len) ? m_want : m_len;
	assign m_2       = (m_1 < MAXR_C) ? m_1 : MAXR_C;
	assign n_c       = KW'(m_2);
	assign byte_addr = rdbase_q + TW'(k_q);

	assign out_free  = !out_valid_q || !rsp_stall;

	assign ram_we    = (cmd.push_step && do_wr) || cmd.hdr_write;
	assign ram_waddr = cmd.hdr_write ? hdr_pos[AW-1:0] : push_addr[AW-1:0];
	assign ram_wdata = cmd.hdr_write ? hdr_byte : byte_q;
	assign ram_re    = cmd.hdr_rd_addr || cmd.byte_rd;
	assign ram_raddr = cmd.hdr_rd_addr ? hra[AW-1:0] : byte_addr[AW-1:0];

	always_comb begin
		sts             = '0;
		sts.func        = func_q;
		sts.push_commit = commit;
		sts.stack_empty = top_q >= STORE_T;
		sts.hdr_last    = idx_q == HB_LAST;
		sts.idx_zero    = idx_q == '0;
		sts.n_zero      = n_c == '0;
		sts.byte_last   = (k_q + KW'(1)) == n_q;
		sts.out_free    = out_free;
	end

	vrs_ram #(
		.WIDTH(BW),
		.DEPTH(STORE_BYTES)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_q           <= STORE_T;
			push_active_q   <= 1'b0;
			push_base_q     <= '0;
			push_index_q    <= '0;
			push_rejected_q <= 1'b0;
			out_valid_q     <= 1'b0;
		end else begin
			if (cmd.do_clear || cmd.read_start) begin
				push_active_q   <= 1'b0;
				push_base_q     <= '0;
				push_index_q    <= '0;
				push_rejected_q <= 1'b0;
			end
			if (cmd.do_clear) begin
				top_q <= STORE_T;
			end
			if (cmd.push_step) begin
				if (eff_rej) begin
					if (rej_clr) begin
						push_active_q   <= 1'b0;
						push_base_q     <= '0;
						push_index_q    <= '0;
						push_rejected_q <= 1'b0;
					end else begin
						push_active_q   <= 1'b1;
						push_rejected_q <= 1'b1;
						push_index_q    <= '0;
					end
				end else begin
					push_active_q   <= 1'b1;
					push_rejected_q <= 1'b0;
					push_base_q     <= eff_base;
					push_index_q    <= idx_next;
				end
			end
			if (cmd.hdr_write && (idx_q == HB_LAST)) begin
				top_q           <= hdr_base;
				push_active_q   <= 1'b0;
				push_base_q     <= '0;
				push_index_q    <= '0;
				push_rejected_q <= 1'b0;
			end
			if (cmd.calc && (func_q == vrs_pkg::FN_POP)) begin
				top_q <= data_fits ? (data_c + len_clamp) : STORE_T;
			end
			if (cmd.emit_single || cmd.emit_byte) begin
				out_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload and scratch
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			func_q    <= vrs_pkg::func_t'(func);
			rec_len_q <= record_length;
			want_q    <= wanted_bytes;
			byte_q    <= data_byte;
			eor_q     <= end_of_record;
		end
		if (cmd.do_clear) begin
			res_status_q <= vrs_pkg::ST_OK;
		end
		if (cmd.push_step) begin
			res_status_q <= eff_rej ? vrs_pkg::ST_NO_ROOM : vrs_pkg::ST_OK;
			idx_q        <= '0;
		end
		if (cmd.hdr_write) begin
			idx_q <= idx_q + HIW'(1);
		end
		if (cmd.read_start) begin
			res_status_q <= (top_q >= STORE_T) ? vrs_pkg::ST_EMPTY : vrs_pkg::ST_OK;
			idx_q        <= HB_LAST;
			len_q        <= '0;
		end
		if (cmd.hdr_rd_addr) begin
			oob_q <= hra >= STORE_T;
		end
		if (cmd.hdr_acc) begin
			len_q <= len_cat[TW-1:0];
			idx_q <= idx_q - HIW'(1);
		end
		if (cmd.calc) begin
			res_status_q <= vrs_pkg::ST_OK;
			n_q          <= n_c;
			k_q          <= '0;
			rdbase_q     <= data_c;
		end
		if (cmd.byte_rd) begin
			oob_q <= 1'b0;
		end
		if (cmd.emit_byte) begin
			k_q <= k_q + KW'(1);
		end
		if (cmd.emit_single) begin
			out_status_q <= res_status_q;
			out_byte_q   <= '0;
			out_bv_q     <= 1'b0;
			out_last_q   <= 1'b1;
			out_free_q   <= top_c[vrs_pkg::FREE_W-1:0];
			out_empty_q  <= top_q == STORE_T;
		end
		if (cmd.emit_byte) begin
			out_status_q <= vrs_pkg::ST_OK;
			out_byte_q   <= rd_byte;
			out_bv_q     <= 1'b1;
			out_last_q   <= (k_q + KW'(1)) == n_q;
			out_free_q   <= top_c[vrs_pkg::FREE_W-1:0];
			out_empty_q  <= top_q == STORE_T;
		end
	end

	assign rsp_valid  = out_valid_q;
	assign status     = out_status_q;
	assign out_byte   = out_byte_q;
	assign byte_valid = out_bv_q;
	assign last       = out_last_q;
	assign free_bytes = out_free_q;
	assign is_empty   = out_empty_q;

endmodule
`default_nettype wire

>>> rtl/core/variable_record_stack.sv
// Top level of the variable record stack.
//
// A stack of variable-length byte records in a byte store growing downward;
// each record sits above a little-endian length header.
// Request channel req_*: one beat per push byte, clear, pop or peek.
// Response channel rsp_*: one beat per push byte, clear or pop/peek that
// returns no byte, else one per returned byte (last marks the final).
// Both channels: a beat moves when valid is high and stall is low.
// Requests are taken one at a time: req_stall is low only while the
// controller is idle. A clear or a plain push byte passes the operation and
// emit states into the output register; an accepted push's closing byte adds
// HEADER_BYTES header writes through the single RAM write port. As the RAM
// read is registered, pop and peek take an address and an accumulate state
// per header byte, a calc state for the length, then a read and an emit
// state per returned byte. A result waits in the output register while
// rsp_stall is high; the controller holds until that register frees.
// Reset empties the stack and drops any push in progress; the store itself
// is not cleared and needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module variable_record_stack #(
	parameter int STORE_BYTES  = vrs_pkg::STORE_BYTES_DEF,
	parameter int HEADER_BYTES = vrs_pkg::HEADER_BYTES_DEF,
	parameter int MAX_READ     = vrs_pkg::MAX_READ_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          req_valid,
	output logic                               req_stall,
	input  wire logic [vrs_pkg::FUNC_W-1:0]    func,
	input  wire logic [vrs_pkg::REC_LEN_W-1:0] record_length,
	input  wire logic [vrs_pkg::WANT_W-1:0]    wanted_bytes,
	input  wire logic [vrs_pkg::BYTE_W-1:0]    data_byte,
	input  wire logic                          end_of_record,
	output logic                               rsp_valid,
	input  wire logic                          rsp_stall,
	output logic      [vrs_pkg::STATUS_W-1:0]  status,
	output logic      [vrs_pkg::BYTE_W-1:0]    out_byte,
	output logic                               byte_valid,
	output logic                               last,
	output logic      [vrs_pkg::FREE_W-1:0]    free_bytes,
	output logic                               is_empty
);

	vrs_pkg::cmd_t cmd;
	vrs_pkg::sts_t sts;

	vrs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	vrs_datapath #(
		.STORE_BYTES (STORE_BYTES),
		.HEADER_BYTES(HEADER_BYTES),
		.MAX_READ    (MAX_READ)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.func         (func),
		.record_length(record_length),
		.wanted_bytes (wanted_bytes),
		.data_byte    (data_byte),
		.end_of_record(end_of_record),
		.rsp_valid    (rsp_valid),
		.rsp_stall    (rsp_stall),
		.status       (status),
		.out_byte     (out_byte),
		.byte_valid   (byte_valid),
		.last         (last),
		.free_bytes   (free_bytes),
		.is_empty     (is_empty)
	);

endmodule
`default_nettype wire

>>> rtl/core/vrs_checker.sv
// Port-level checks for the variable record stack, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module vrs_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          rsp_valid,
	input wire logic                          rsp_stall,
	input wire logic [vrs_pkg::STATUS_W-1:0]  status,
	input wire logic [vrs_pkg::BYTE_W-1:0]    out_byte,
	input wire logic                          byte_valid,
	input wire logic                          last,
	input wire logic                          is_empty
);

	// stalled beat holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(out_byte) && $stable(last)
			&& $stable(status))
		else $error("response beat changed while stalled");

	a_empty_beat: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (status == vrs_pkg::ST_EMPTY) |-> last && is_empty && !byte_valid)
		else $error("empty status beat malformed");

	a_no_room_beat: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (status == vrs_pkg::ST_NO_ROOM) |-> last && !byte_valid)
		else $error("no-room beat malformed");

	a_idle_byte: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !byte_valid |-> (out_byte == '0) && last)
		else $error("beat without data carries a byte or is not last");

endmodule

bind variable_record_stack vrs_checker u_vrs_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.status    (status),
	.out_byte  (out_byte),
	.byte_valid(byte_valid),
	.last      (last),
	.is_empty  (is_empty)
);
`default_nettype wire
